/* rtl/core/i2a_pkg.sv */
package i2a_pkg;

	// ASCII codes used by the character formatter.
	localparam logic [6:0] ASCII_MINUS    = 7'h2d;
	localparam logic [6:0] ASCII_ZERO     = 7'h30;
	// 'a' minus ten, so that digit ten maps onto 'a'.
	localparam logic [6:0] ASCII_HEX_BASE = 7'h57;
	localparam logic [3:0] DIGIT_TEN      = 4'd10;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic conv;
		logic skip;
		logic sign;
		logic emit;
	} i2a_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic conv_last;
		logic top_zero;
		logic cnt_one;
		logic neg;
	} i2a_sts_t;

	// Maps one digit (0..15) onto its lower-case ASCII character.
	function automatic logic [6:0] digit_char(input logic [3:0] d);
		logic [6:0] c;
		if (d < DIGIT_TEN) begin
			c = ASCII_ZERO + {3'b000, d};
		end else begin
			c = ASCII_HEX_BASE + {3'b000, d};
		end
		return c;
	endfunction

endpackage

/* rtl/core/integer_to_ascii_converter_unit.sv */
// Channel   Handshake                  Payload
// --------  -------------------------  ---------------------------------
// request   start (taken when !busy)   value (signed), hex_mode
// result    char_valid (one cycle)     ascii_char, last
//
// Each request is rendered as ASCII text, one character per result, most
// significant character first. A decimal request passes through the
// shift-and-add-3 converter, and a hex request loads its digits directly.
// The digit register then strips leading zeros one digit per cycle and emits
// one character per cycle, with a minus sign first for a negative value. The
// digit register holds NDIG digits, where NDIG is the decimal digit count of
// 2^(VALUE_WIDTH-1) (ten at 32 bits). Reset clears the controller and the
// result strobe. The receiver cannot stall results.
module integer_to_ascii_converter_unit
	import i2a_pkg::*;
#(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic signed [VALUE_WIDTH-1:0] value,
	input  logic                          hex_mode,
	output logic                          busy,
	output logic                          char_valid,
	output logic [6:0]                    ascii_char,
	output logic                          last
);

	i2a_cmd_t cmd;
	i2a_sts_t sts;

	// The controller sequences load, conversion, zero stripping and emission.
	i2a_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.hex_mode (hex_mode),
		.sts      (sts),
		.cmd      (cmd),
		.busy     (busy)
	);

	// The datapath holds the magnitude, the digit register and the result register.
	i2a_datapath #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.value      (value),
		.hex_mode   (hex_mode),
		.sts        (sts),
		.char_valid (char_valid),
		.ascii_char (ascii_char),
		.last       (last)
	);

endmodule

/* rtl/core/i2a_ctrl.sv */
module i2a_ctrl
	import i2a_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  logic     hex_mode,
	input  i2a_sts_t sts,
	output i2a_cmd_t cmd,
	output logic     busy
);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_CONV = 5'b00010,
		ST_SKIP = 5'b00100,
		ST_SIGN = 5'b01000,
		ST_EMIT = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = hex_mode ? ST_SKIP : ST_CONV;
				end
			end
			ST_CONV: begin
				cmd.conv = 1'b1;
				if (sts.conv_last) begin
					state_d = ST_SKIP;
				end
			end
			ST_SKIP: begin
				// Strip leading zero digits, but always keep the last one.
				if (sts.top_zero && !sts.cnt_one) begin
					cmd.skip = 1'b1;
				end else begin
					state_d = sts.neg ? ST_SIGN : ST_EMIT;
				end
			end
			ST_SIGN: begin
				cmd.sign = 1'b1;
				state_d  = ST_EMIT;
			end
			ST_EMIT: begin
				cmd.emit = 1'b1;
				if (sts.cnt_one) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != ST_IDLE);

endmodule

/* rtl/core/i2a_datapath.sv */
module i2a_datapath
	import i2a_pkg::*;
#(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  i2a_cmd_t                      cmd,
	input  logic signed [VALUE_WIDTH-1:0] value,
	input  logic                          hex_mode,
	output i2a_sts_t                      sts,
	output logic                          char_valid,
	output logic [6:0]                    ascii_char,
	output logic                          last
);

	// Decimal digits of 2^(VALUE_WIDTH-1); always at least the hex digit count.
	localparam int NDIG = ((VALUE_WIDTH - 1) * 30103) / 100000 + 1;
	localparam int BW   = NDIG * 4;
	localparam int CW   = $clog2(NDIG + 1);
	localparam int KW   = $clog2(VALUE_WIDTH + 1);

	logic [BW-1:0]          bcd_q;
	logic [VALUE_WIDTH-1:0] bin_q;
	logic [KW-1:0]          bitcnt_q;
	logic [CW-1:0]          cnt_q;
	logic                   neg_q;
	logic                   strobe_q;
	logic [6:0]             char_q;
	logic                   last_q;

	logic [VALUE_WIDTH-1:0] mag;
	logic [BW-1:0]          adj;
	logic [3:0]             top;

	// Magnitude of the most negative value wraps to 2^(VALUE_WIDTH-1), as wanted.
	assign mag = value[VALUE_WIDTH-1] ? (~value + 1'b1) : value;
	assign top = bcd_q[BW-1 -: 4];

	// Shift-and-add-3 correction, one independent adjust per BCD digit.
	always_comb begin
		for (int i = 0; i < NDIG; i++) begin
			if (bcd_q[i*4 +: 4] >= 4'd5) begin
				adj[i*4 +: 4] = bcd_q[i*4 +: 4] + 4'd3;
			end else begin
				adj[i*4 +: 4] = bcd_q[i*4 +: 4];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			neg_q    <= value[VALUE_WIDTH-1];
			bin_q    <= mag;
			bitcnt_q <= KW'(VALUE_WIDTH);
			cnt_q    <= CW'(NDIG);
			if (hex_mode) begin
				bcd_q <= BW'(mag);
			end else begin
				bcd_q <= '0;
			end
		end else if (cmd.conv) begin
			bcd_q    <= {adj[BW-2:0], bin_q[VALUE_WIDTH-1]};
			bin_q    <= {bin_q[VALUE_WIDTH-2:0], 1'b0};
			bitcnt_q <= bitcnt_q - 1'b1;
		end else if (cmd.skip || cmd.emit) begin
			bcd_q <= {bcd_q[BW-5:0], 4'h0};
			cnt_q <= cnt_q - 1'b1;
		end
		if (cmd.sign) begin
			char_q <= ASCII_MINUS;
			last_q <= 1'b0;
		end else if (cmd.emit) begin
			char_q <= digit_char(top);
			last_q <= sts.cnt_one;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= cmd.sign | cmd.emit;
		end
	end

	assign sts.conv_last = (bitcnt_q == KW'(1));
	assign sts.top_zero  = (top == 4'h0);
	assign sts.cnt_one   = (cnt_q == CW'(1));
	assign sts.neg       = neg_q;

	assign char_valid = strobe_q;
	assign ascii_char = char_q;
	assign last       = last_q;

endmodule
